### hw/rtl/mrc_pkg.sv
// Shared types, constants and per-stage datapath functions for the mixed-radix index codec.
package mrc_pkg;

  // Grid limits
  localparam int unsigned MaxDims   = 4;
  localparam int unsigned CoordBits = 8;
  localparam int unsigned NumFields = 4;
  localparam int unsigned DimLim    = (MaxDims < NumFields) ? MaxDims : NumFields;

  // Field widths
  localparam int unsigned IdxBits  = 32;
  localparam int unsigned SizeBits = 9;
  localparam int unsigned DimBits  = 3;
  localparam int unsigned ProdBits = IdxBits + 1;
  localparam int unsigned SelBits  = $clog2(NumFields);

  // Pipeline shape: entry stage, division stages, final stage
  localparam int unsigned StepsPerStage = 8;
  localparam int unsigned StagesPerDiv  = IdxBits / StepsPerStage;
  localparam int unsigned NumDivs       = NumFields - 1;
  localparam int unsigned NumStages     = 1 + StagesPerDiv * NumDivs + 1;
  localparam int unsigned RangeStage    = NumFields;

  localparam logic [SizeBits-1:0] SizeCap = SizeBits'(1 << CoordBits);

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgNumDims   = 3'd0,
    CfgDimSize0  = 3'd1,
    CfgDimSize1  = 3'd2,
    CfgDimSize2  = 3'd3,
    CfgDimSize3  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                 req_type;
    logic [IdxBits-1:0]   in_flat_index;
    logic [CoordBits-1:0] in_coord_0;
    logic [CoordBits-1:0] in_coord_1;
    logic [CoordBits-1:0] in_coord_2;
    logic [CoordBits-1:0] in_coord_3;
  } in_item_t;

  typedef struct packed {
    logic [IdxBits-1:0]   out_flat_index;
    logic [CoordBits-1:0] out_coord_0;
    logic [CoordBits-1:0] out_coord_1;
    logic [CoordBits-1:0] out_coord_2;
    logic [CoordBits-1:0] out_coord_3;
    logic                 out_of_range;
  } out_item_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [DimBits-1:0]                  n;
    logic [NumFields-1:0][SizeBits-1:0]  size;
  } cfg_t;

  // Item state carried down the pipeline
  typedef struct packed {
    logic                                cmp;
    logic [IdxBits-1:0]                  idx;
    logic [IdxBits-1:0]                  q;
    logic [CoordBits-1:0]                rem;
    logic [NumFields-1:0][CoordBits-1:0] cin;
    logic [NumFields-1:0][CoordBits-1:0] cout;
    logic [IdxBits-1:0]                  flat;
    logic [ProdBits-1:0]                 prod;
    logic                                oor;
  } pipe_t;

  // Entry stage: load working registers, handle dimension zero of compose
  function automatic pipe_t entry_fn(in_item_t it, cfg_t cfg);
    pipe_t p;
    p.cmp    = it.req_type;
    p.idx    = it.in_flat_index;
    p.q      = it.in_flat_index;
    p.rem    = '0;
    p.cin[0] = it.in_coord_0;
    p.cin[1] = it.in_coord_1;
    p.cin[2] = it.in_coord_2;
    p.cin[3] = it.in_coord_3;
    p.cout   = '0;
    p.flat   = IdxBits'(it.in_coord_0);
    p.prod   = ProdBits'(cfg.size[0]);
    p.oor    = ({1'b0, it.in_coord_0} >= cfg.size[0]);
    return p;
  endfunction

  // One compose term and one stride product for a higher dimension
  function automatic pipe_t grid_fn(pipe_t p, cfg_t cfg, logic [SelBits-1:0] dim);
    pipe_t r;
    logic [SizeBits-1:0] s;
    r = p;
    s = cfg.size[dim];
    if ({1'b0, dim} < cfg.n) begin
      r.flat = p.flat + IdxBits'(p.cin[dim] * p.prod);
      r.oor  = p.oor | ({1'b0, p.cin[dim]} >= s);
      r.prod = ProdBits'(p.prod * s);
    end
    return r;
  endfunction

  // Decompose range check against the grid total
  function automatic pipe_t range_fn(pipe_t p);
    pipe_t r;
    r = p;
    if (!p.cmp) begin
      r.oor = ({1'b0, p.idx} >= p.prod);
    end
    return r;
  endfunction

  // Divisor for a division group; dims at or past the last used one divide by one
  function automatic logic [SizeBits-1:0] div_size(cfg_t cfg, logic [SelBits-1:0] g);
    logic [SizeBits-1:0] d;
    if (DimBits'(g) + DimBits'(1) < cfg.n) begin
      d = cfg.size[g];
    end else begin
      d = SizeBits'(1);
    end
    return d;
  endfunction

  // Restoring division, a few quotient bits per stage
  function automatic pipe_t div_fn(pipe_t p, logic [SizeBits-1:0] d, logic first,
                                   logic last, logic [SelBits-1:0] dim);
    pipe_t                r;
    logic [CoordBits-1:0] rm;
    logic [SizeBits-1:0]  r9;
    logic [IdxBits-1:0]   q;
    r  = p;
    rm = first ? '0 : p.rem;
    q  = p.q;
    for (int i = 0; i < StepsPerStage; i++) begin
      r9 = {rm, q[IdxBits-1]};
      q  = {q[IdxBits-2:0], 1'b0};
      if (r9 >= d) begin
        r9   = r9 - d;
        q[0] = 1'b1;
      end
      rm = r9[CoordBits-1:0];
    end
    r.rem = rm;
    r.q   = q;
    if (last) begin
      r.cout[dim] = rm;
    end
    return r;
  endfunction

  // Final stage: top coordinate takes the quotient, clear unused outputs
  function automatic pipe_t final_fn(pipe_t p, cfg_t cfg);
    pipe_t              r;
    logic [SelBits-1:0] top;
    r   = p;
    top = SelBits'(cfg.n - DimBits'(1));
    if (p.cmp) begin
      r.cout = '0;
    end else begin
      r.flat      = '0;
      r.cout[top] = p.q[CoordBits-1:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/mrc_cfg_regs.sv
// Configuration registers with clamping to effective dimension count and sizes.
module mrc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [mrc_pkg::SizeBits-1:0] cfg_wdata_i,
  output mrc_pkg::cfg_t                cfg_o
);

  logic [mrc_pkg::DimBits-1:0]                           num_dims_q;
  logic [mrc_pkg::NumFields-1:0][mrc_pkg::SizeBits-1:0]  dim_size_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= mrc_pkg::DimBits'(1);
      for (int i = 0; i < mrc_pkg::NumFields; i++) begin
        dim_size_q[i] <= mrc_pkg::SizeBits'(1);
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mrc_pkg::CfgNumDims:  num_dims_q    <= cfg_wdata_i[mrc_pkg::DimBits-1:0];
        mrc_pkg::CfgDimSize0: dim_size_q[0] <= cfg_wdata_i;
        mrc_pkg::CfgDimSize1: dim_size_q[1] <= cfg_wdata_i;
        mrc_pkg::CfgDimSize2: dim_size_q[2] <= cfg_wdata_i;
        mrc_pkg::CfgDimSize3: dim_size_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp: zero means one, too large saturates
  always_comb begin
    if (num_dims_q == '0) begin
      cfg_o.n = mrc_pkg::DimBits'(1);
    end else if (num_dims_q > mrc_pkg::DimBits'(mrc_pkg::DimLim)) begin
      cfg_o.n = mrc_pkg::DimBits'(mrc_pkg::DimLim);
    end else begin
      cfg_o.n = num_dims_q;
    end
    for (int i = 0; i < mrc_pkg::NumFields; i++) begin
      if (dim_size_q[i] == '0) begin
        cfg_o.size[i] = mrc_pkg::SizeBits'(1);
      end else if (dim_size_q[i] > mrc_pkg::SizeCap) begin
        cfg_o.size[i] = mrc_pkg::SizeCap;
      end else begin
        cfg_o.size[i] = dim_size_q[i];
      end
    end
  end

endmodule

### hw/rtl/mrc_pipe_stage.sv
// One pipeline register stage with valid bit and backpressure.
module mrc_pipe_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  mrc_pkg::pipe_t data_i,
  output logic           ready_o,
  output logic           valid_o,
  output mrc_pkg::pipe_t data_o,
  input  logic           ready_i
);

  logic           valid_q;
  logic           valid_d;
  mrc_pkg::pipe_t data_q;

  // Stage takes a new item when empty or when its item moves on
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hw/rtl/mixed_radix_index_codec_core.sv
// 14 register stages: entry, 12 division, final.
// Throughput: one item per cycle unless out_stall_i holds the pipeline; each
// division stage retires 8 quotient bits of a 32-bit index, three divisions in
// series, so 12 stages set the depth.
// Bubbles are squeezed out: an item is taken while a finished result waits.
// Reset clears all stage valid bits and sets every config register to 1.
// Top level of the mixed-radix index codec.
module mixed_radix_index_codec_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [mrc_pkg::SizeBits-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  mrc_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output mrc_pkg::out_item_t           out_data_o
);

  localparam int unsigned Last = mrc_pkg::NumStages - 1;

  mrc_pkg::cfg_t                       cfg;
  mrc_pkg::pipe_t                      st_q [mrc_pkg::NumStages];
  logic [mrc_pkg::NumStages-1:0]       vld;
  logic [mrc_pkg::NumStages-1:0]       rdy;
  mrc_pkg::pipe_t                      lst;

  mrc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Pipeline stages
  for (genvar k = 0; k < mrc_pkg::NumStages; k++) begin : g_stage
    mrc_pkg::pipe_t nxt;
    logic           vin;
    logic           rin;

    if (k == 0) begin : g_entry
      assign nxt = mrc_pkg::entry_fn(in_data_i, cfg);
      assign vin = in_valid_i;
    end else if (k == Last) begin : g_final
      assign nxt = mrc_pkg::final_fn(st_q[k-1], cfg);
      assign vin = vld[k-1];
    end else begin : g_div
      localparam int unsigned G = (k - 1) / mrc_pkg::StagesPerDiv;
      localparam int unsigned S = (k - 1) % mrc_pkg::StagesPerDiv;
      localparam logic [mrc_pkg::SelBits-1:0] Dim = mrc_pkg::SelBits'(G);
      mrc_pkg::pipe_t pre;

      // Compose terms and range check ride along with the first divisions
      always_comb begin
        pre = st_q[k-1];
        if (k < mrc_pkg::NumFields) begin
          pre = mrc_pkg::grid_fn(pre, cfg, mrc_pkg::SelBits'(k));
        end
        if (k == mrc_pkg::RangeStage) begin
          pre = mrc_pkg::range_fn(pre);
        end
      end

      assign nxt = mrc_pkg::div_fn(pre, mrc_pkg::div_size(cfg, Dim), S == 0,
                                   S == mrc_pkg::StagesPerDiv - 1, Dim);
      assign vin = vld[k-1];
    end

    if (k == Last) begin : g_rdy_out
      assign rin = !out_stall_i;
    end else begin : g_rdy_mid
      assign rin = rdy[k+1];
    end

    mrc_pipe_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vin),
      .data_i  (nxt),
      .ready_o (rdy[k]),
      .valid_o (vld[k]),
      .data_o  (st_q[k]),
      .ready_i (rin)
    );
  end

  // Output mapping from the last stage register
  assign lst         = st_q[Last];
  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld[Last];

  assign out_data_o.out_flat_index = lst.flat;
  assign out_data_o.out_coord_0    = lst.cout[0];
  assign out_data_o.out_coord_1    = lst.cout[1];
  assign out_data_o.out_coord_2    = lst.cout[2];
  assign out_data_o.out_coord_3    = lst.cout[3];
  assign out_data_o.out_of_range   = lst.oor;

`ifndef SYNTHESIS
  // Decompose results never carry a flat index
  a_dec_flat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !lst.cmp |-> out_data_o.out_flat_index == '0)
    else $error("decompose item with nonzero flat index");

  // Compose results carry no coordinates
  a_cmp_coord_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lst.cmp |-> lst.cout == '0)
    else $error("compose item with nonzero coordinates");

  // Single-dimension decompose fills only coordinate zero
  a_one_dim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !lst.cmp && cfg.n == mrc_pkg::DimBits'(1)
    |-> out_data_o.out_coord_1 == '0 && out_data_o.out_coord_2 == '0
        && out_data_o.out_coord_3 == '0)
    else $error("unused coordinate set with one dimension");

  // Input is held off only when the entry stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> vld[0])
    else $error("input stalled with empty entry stage");
`endif

endmodule
